// ===== src/puh_pkg.sv =====
`default_nettype none

package puh_pkg;

    // number of port bins and width of one counter
    localparam int NUM_PORTS   = 65536;
    localparam int COUNT_WIDTH = 32;
    localparam int ADDR_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // fixed field widths
    localparam int PORT_W = 16;
    localparam int SECS_W = 32;
    localparam int LEN_W  = 17;
    localparam int OUT_W  = 32;

    // request codes
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    // status of the remainder unit seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } puh_rem_stat_t;

    // bin exists for this port number
    function automatic logic port_in_range(input logic [PORT_W-1:0] port);
        port_in_range = ({1'b0, port} < (PORT_W+1)'(NUM_PORTS));
    endfunction

    // port number to bin address
    function automatic addr_t port_addr(input logic [PORT_W-1:0] port);
        logic [PORT_W+ADDR_W-1:0] ext;
        ext       = (PORT_W+ADDR_W)'(port);
        port_addr = ext[ADDR_W-1:0];
    endfunction

    // add one, sticking at the maximum
    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == {COUNT_WIDTH{1'b1}}) ? c : c + count_t'(1);
    endfunction

    // counter clipped to the reported width
    function automatic logic [OUT_W-1:0] report_count(input count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        if (wide[63:OUT_W] != '0) begin
            report_count = {OUT_W{1'b1}};
        end else begin
            report_count = wide[OUT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/port_usage_histogram.sv =====
`default_nettype none

// Port usage histogram: one saturating packet counter per port number, held in a
// single-port-write, registered-read counter memory. After reset the block sweeps
// the whole memory to zero, one bin per cycle, and s_ready stays low until the
// sweep is done; cfg writes are taken at any time. A read request first presents
// its address to the memory, then moves the registered memory data into the
// output register, and holds at that step while an earlier result is not yet
// taken. A counted packet does a read-modify-write of the source bin overlapped
// with the read of the destination bin, then the destination write, so the
// memory port sets the rate. A packet that starts a new interval first sweeps
// all bins while a bit-serial remainder unit aligns the interval start, then
// counts as above. Packets that are not TCP or UDP are taken without leaving
// the idle state and change nothing.
module port_usage_histogram (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration: interval length in seconds
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [puh_pkg::LEN_W-1:0]    cfg_data,
    // requests
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_req_type,
    input  wire logic                         s_is_new_interval,
    input  wire logic                         s_is_tcp_or_udp,
    input  wire logic [puh_pkg::SECS_W-1:0]   s_time_seconds,
    input  wire logic [puh_pkg::PORT_W-1:0]   s_source_port,
    input  wire logic [puh_pkg::PORT_W-1:0]   s_dest_port,
    input  wire logic [puh_pkg::PORT_W-1:0]   s_read_index,
    // results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [puh_pkg::SECS_W-1:0]        m_interval_start,
    output logic [puh_pkg::PORT_W-1:0]        m_bin_port,
    output logic [puh_pkg::OUT_W-1:0]         m_bin_count
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_SRC,
        ST_WR_SRC,
        ST_WR_DST,
        ST_RD_OUT
    } state_t;

    state_t                      state_reg;
    logic [puh_pkg::LEN_W-1:0]   interval_secs_reg;
    logic [puh_pkg::SECS_W-1:0]  interval_base_reg;
    puh_pkg::addr_t              clr_addr_reg;
    logic                        pend_reg;
    logic [puh_pkg::PORT_W-1:0]  src_reg;
    logic [puh_pkg::PORT_W-1:0]  dst_reg;
    logic [puh_pkg::PORT_W-1:0]  idx_reg;
    puh_pkg::count_t             fwd_reg;
    logic                        m_valid_reg;
    logic [puh_pkg::SECS_W-1:0]  m_start_reg;
    logic [puh_pkg::PORT_W-1:0]  m_port_reg;
    logic [puh_pkg::OUT_W-1:0]   m_count_reg;

    logic                        s_fire;
    logic                        out_free;
    logic                        clr_last;
    logic                        rem_start;
    logic [puh_pkg::SECS_W-1:0]  rem_base;
    puh_pkg::puh_rem_stat_t      rem_stat;

    logic                        mem_we;
    puh_pkg::addr_t              mem_waddr;
    puh_pkg::count_t             mem_wdata;
    puh_pkg::addr_t              mem_raddr;
    puh_pkg::count_t             mem_rdata;
    puh_pkg::count_t             src_inc;
    puh_pkg::count_t             dst_old;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign clr_last  = (clr_addr_reg == puh_pkg::addr_t'(puh_pkg::NUM_PORTS - 1));
    assign rem_start = s_fire && (s_req_type == puh_pkg::REQ_COUNT)
                       && s_is_tcp_or_udp && s_is_new_interval;

    // counter update values, with forwarding when both ports hit one bin
    assign src_inc = puh_pkg::sat_inc(mem_rdata);
    assign dst_old = (dst_reg == src_reg) ? fwd_reg : mem_rdata;

    // memory address and write selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = puh_pkg::port_addr(src_reg);
        mem_wdata = src_inc;
        mem_raddr = puh_pkg::port_addr(idx_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                mem_raddr = (s_req_type == puh_pkg::REQ_READ)
                            ? puh_pkg::port_addr(s_read_index)
                            : puh_pkg::port_addr(s_source_port);
            end
            ST_RD_SRC: begin
                mem_raddr = puh_pkg::port_addr(src_reg);
            end
            ST_WR_SRC: begin
                mem_we    = puh_pkg::port_in_range(src_reg);
                mem_raddr = puh_pkg::port_addr(dst_reg);
            end
            ST_WR_DST: begin
                mem_we    = puh_pkg::port_in_range(dst_reg);
                mem_waddr = puh_pkg::port_addr(dst_reg);
                mem_wdata = puh_pkg::sat_inc(dst_old);
            end
            ST_RD_OUT: begin
                mem_raddr = puh_pkg::port_addr(idx_reg);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            pend_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
            interval_secs_reg <= puh_pkg::LEN_W'(1);
            interval_base_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                interval_secs_reg <= cfg_data;
            end
            if (rem_stat.done) begin
                interval_base_reg <= rem_base;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + puh_pkg::addr_t'(1);
                    if (clr_last && !rem_stat.busy && !rem_start) begin
                        state_reg <= pend_reg ? ST_RD_SRC : ST_IDLE;
                        pend_reg  <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        src_reg <= s_source_port;
                        dst_reg <= s_dest_port;
                        idx_reg <= s_read_index;
                        if (s_req_type == puh_pkg::REQ_READ) begin
                            state_reg <= ST_RD_OUT;
                        end else if (s_is_tcp_or_udp && s_is_new_interval) begin
                            clr_addr_reg <= '0;
                            pend_reg     <= 1'b1;
                            state_reg    <= ST_CLEAR;
                        end else if (s_is_tcp_or_udp) begin
                            state_reg <= ST_WR_SRC;
                        end
                    end
                end
                ST_RD_SRC: begin
                    state_reg <= ST_WR_SRC;
                end
                ST_WR_SRC: begin
                    fwd_reg   <= src_inc;
                    state_reg <= ST_WR_DST;
                end
                ST_WR_DST: begin
                    state_reg <= ST_IDLE;
                end
                ST_RD_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_start_reg <= interval_base_reg;
                        m_port_reg  <= idx_reg;
                        m_count_reg <= puh_pkg::port_in_range(idx_reg)
                                       ? puh_pkg::report_count(mem_rdata) : '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_interval_start = m_start_reg;
    assign m_bin_port       = m_port_reg;
    assign m_bin_count      = m_count_reg;

    // counter memory
    puh_count_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // interval alignment: seconds modulo interval length
    puh_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rem_start),
        .secs    (s_time_seconds),
        .len     (interval_secs_reg),
        .base    (rem_base),
        .stat    (rem_stat)
    );

endmodule

`default_nettype wire

// ===== src/puh_count_mem.sv =====
`default_nettype none

module puh_count_mem (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire puh_pkg::addr_t  waddr,
    input  wire puh_pkg::count_t wdata,
    input  wire puh_pkg::addr_t  raddr,
    output puh_pkg::count_t      rdata
);

    puh_pkg::count_t mem [puh_pkg::NUM_PORTS];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/puh_rem_unit.sv =====
`default_nettype none

module puh_rem_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [puh_pkg::SECS_W-1:0]    secs,
    input  wire logic [puh_pkg::LEN_W-1:0]     len,
    output logic [puh_pkg::SECS_W-1:0]         base,
    output puh_pkg::puh_rem_stat_t             stat
);

    logic [puh_pkg::SECS_W-1:0] secs_reg;
    logic [puh_pkg::SECS_W-1:0] quo_reg;
    logic [puh_pkg::LEN_W-1:0]  div_reg;
    logic [puh_pkg::LEN_W-1:0]  rem_reg;
    logic [puh_pkg::LEN_W-1:0]  rem_next;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [puh_pkg::LEN_W:0]    shifted;
    logic [puh_pkg::LEN_W:0]    diff;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        shifted  = {rem_reg, quo_reg[puh_pkg::SECS_W-1]};
        diff     = shifted - {1'b0, div_reg};
        rem_next = diff[puh_pkg::LEN_W] ? shifted[puh_pkg::LEN_W-1:0]
                                        : diff[puh_pkg::LEN_W-1:0];
    end

    // step control, one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(puh_pkg::SECS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            secs_reg <= secs;
            quo_reg  <= secs;
            rem_reg  <= '0;
            div_reg  <= (len == '0) ? puh_pkg::LEN_W'(1) : len;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[puh_pkg::SECS_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // aligned start: seconds less the remainder
    assign base      = secs_reg - puh_pkg::SECS_W'(rem_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== src/puh_checker.sv =====
`default_nettype none

module puh_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         s_req_type,
    input wire logic                         s_is_tcp_or_udp,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [puh_pkg::SECS_W-1:0]   m_interval_start,
    input wire logic [puh_pkg::PORT_W-1:0]   m_bin_port,
    input wire logic [puh_pkg::OUT_W-1:0]    m_bin_count
);

    // the clearing sweep holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("request taken before the clearing sweep");

    // a stalled result keeps its contents
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_count)
                                && $stable(m_bin_port) && $stable(m_interval_start))
        else $error("result changed while stalled");

    // a read request with a free output shows its result from the output register, loaded in the read-out state
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type && !m_valid |=> !m_valid ##1 m_valid)
        else $error("read result not delivered on time");

    // a count request makes no result
    a_count_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req_type && !m_valid |=> !m_valid)
        else $error("count request produced a result");

    // a counted packet holds off the next request while it updates the counter memory
    a_count_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req_type && s_is_tcp_or_udp |=> !s_ready)
        else $error("new request taken during a counter update");

endmodule

bind port_usage_histogram puh_checker u_chk (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import puh_pkg::*;

    // cycles with no handshake on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 4 * NUM_PORTS + 4000;
    // length of the long receiver hold-off
    localparam int RX_HOLD = 400;
    // largest value the result count can show
    localparam logic [63:0] SHOWN_MAX = (64'd1 << OUT_W) - 64'd1;

    typedef struct {
        logic              req_type;
        logic              is_new_interval;
        logic              is_tcp_or_udp;
        logic [SECS_W-1:0] time_seconds;
        logic [PORT_W-1:0] source_port;
        logic [PORT_W-1:0] dest_port;
        logic [PORT_W-1:0] read_index;
    } hist_req_t;

    typedef struct {
        logic [SECS_W-1:0] interval_start;
        logic [PORT_W-1:0] bin_port;
        logic [OUT_W-1:0]  bin_count;
    } bin_reading_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data  = '0;

    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic              s_req_type        = REQ_COUNT;
    logic              s_is_new_interval = 1'b0;
    logic              s_is_tcp_or_udp   = 1'b0;
    logic [SECS_W-1:0] s_time_seconds    = '0;
    logic [PORT_W-1:0] s_source_port     = '0;
    logic [PORT_W-1:0] s_dest_port       = '0;
    logic [PORT_W-1:0] s_read_index      = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [SECS_W-1:0] m_interval_start;
    logic [PORT_W-1:0] m_bin_port;
    logic [OUT_W-1:0]  m_bin_count;

    // histogram state as the block should hold it
    count_t            tally [logic [PORT_W-1:0]];
    logic [SECS_W-1:0] base_secs    = '0;
    logic [LEN_W-1:0]  interval_len = LEN_W'(1);

    hist_req_t    pending[$];
    bin_reading_t readings_due[$];
    hist_req_t    on_bus;
    logic [PORT_W-1:0] hot_ports [8];

    int unsigned sent_total  = 0;
    int unsigned taken_total = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;
    int unsigned quiet_cycles = 0;

    int unsigned fails           = 0;
    int unsigned reads_checked   = 0;
    int unsigned packets_counted = 0;
    int unsigned packets_ignored = 0;
    int unsigned clears          = 0;
    int unsigned cfg_writes      = 0;

    port_usage_histogram dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_is_new_interval (s_is_new_interval),
        .s_is_tcp_or_udp   (s_is_tcp_or_udp),
        .s_time_seconds    (s_time_seconds),
        .s_source_port     (s_source_port),
        .s_dest_port       (s_dest_port),
        .s_read_index      (s_read_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_interval_start  (m_interval_start),
        .m_bin_port        (m_bin_port),
        .m_bin_count       (m_bin_count)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // one saturating increment of a port bin
    task automatic bump_bin(input logic [PORT_W-1:0] port);
        if (int'(port) < NUM_PORTS) begin
            if (!tally.exists(port)) begin
                tally[port] = '0;
            end
            if (tally[port] != '1) begin
                tally[port] = tally[port] + count_t'(1);
            end
        end
    endtask

    // work out what an accepted request does to the histogram
    task automatic apply_request(input hist_req_t r);
        bin_reading_t      rd;
        logic [SECS_W-1:0] span;
        count_t            c;
        if (r.req_type == REQ_READ) begin
            c = '0;
            if (int'(r.read_index) < NUM_PORTS && tally.exists(r.read_index)) begin
                c = tally[r.read_index];
            end
            rd.interval_start = base_secs;
            rd.bin_port       = r.read_index;
            rd.bin_count      = (64'(c) > SHOWN_MAX) ? '1 : OUT_W'(c);
            readings_due.push_back(rd);
        end else if (r.is_tcp_or_udp) begin
            // a new interval clears every bin and realigns the start first
            if (r.is_new_interval) begin
                span = (interval_len == '0) ? SECS_W'(1) : SECS_W'(interval_len);
                tally.delete();
                base_secs = r.time_seconds - (r.time_seconds % span);
                clears++;
            end
            bump_bin(r.source_port);
            bump_bin(r.dest_port);
            packets_counted++;
        end else begin
            packets_ignored++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin : request_drive
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(on_bus);
                taken_total++;
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    on_bus = pending.pop_front();
                    s_req_type        <= on_bus.req_type;
                    s_is_new_interval <= on_bus.is_new_interval;
                    s_is_tcp_or_udp   <= on_bus.is_tcp_or_udp;
                    s_time_seconds    <= on_bus.time_seconds;
                    s_source_port     <= on_bus.source_port;
                    s_dest_port       <= on_bus.dest_port;
                    s_read_index      <= on_bus.read_index;
                    s_valid           <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin : result_check
        bin_reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result with none due: bin_port %0d", m_bin_port);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_interval_start !== want.interval_start) begin
                        $error("interval_start: expected %0d, actual %0d",
                               want.interval_start, m_interval_start);
                        fails++;
                    end
                    if (m_bin_port !== want.bin_port) begin
                        $error("bin_port: expected %0d, actual %0d",
                               want.bin_port, m_bin_port);
                        fails++;
                    end
                    if (m_bin_count !== want.bin_count) begin
                        $error("bin_count: expected %0d, actual %0d",
                               want.bin_count, m_bin_count);
                        fails++;
                    end
                    reads_checked++;
                end
            end
            // long hold-off when asked, random stalls otherwise
            if (hold_served != hold_asks) begin
                hold_left   = RX_HOLD;
                hold_served = hold_asks;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles", quiet_cycles);
                $display("FAIL port_usage_histogram");
                $finish;
            end
        end
    end

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(3) != 0) begin
            return hot_ports[$urandom_range(7)];
        end
        return PORT_W'($urandom);
    endfunction

    function automatic hist_req_t count_item(input logic new_iv, input logic tcp,
                                             input logic [SECS_W-1:0] secs,
                                             input logic [PORT_W-1:0] sport,
                                             input logic [PORT_W-1:0] dport);
        hist_req_t r;
        r.req_type        = REQ_COUNT;
        r.is_new_interval = new_iv;
        r.is_tcp_or_udp   = tcp;
        r.time_seconds    = secs;
        r.source_port     = sport;
        r.dest_port       = dport;
        r.read_index      = PORT_W'($urandom);
        return r;
    endfunction

    // ignored fields of a read carry random junk
    function automatic hist_req_t read_item(input logic [PORT_W-1:0] idx);
        hist_req_t r;
        r.req_type        = REQ_READ;
        r.is_new_interval = 1'($urandom_range(1));
        r.is_tcp_or_udp   = 1'($urandom_range(1));
        r.time_seconds    = SECS_W'($urandom);
        r.source_port     = PORT_W'($urandom);
        r.dest_port       = PORT_W'($urandom);
        r.read_index      = idx;
        return r;
    endfunction

    // mostly counted packets on a few busy ports, reads of those ports, some noise
    function automatic hist_req_t random_request();
        hist_req_t   r;
        int unsigned pick;
        r.is_new_interval = 1'($urandom_range(1));
        r.is_tcp_or_udp   = 1'($urandom_range(1));
        r.time_seconds    = SECS_W'($urandom);
        r.source_port     = PORT_W'($urandom);
        r.dest_port       = PORT_W'($urandom);
        r.read_index      = PORT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 35) begin
            r.req_type   = REQ_READ;
            r.read_index = pick_port();
        end else begin
            r.req_type      = REQ_COUNT;
            r.is_tcp_or_udp = (pick >= 45);
            if ($urandom_range(3) != 0) begin
                r.source_port = pick_port();
            end
            if ($urandom_range(3) != 0) begin
                r.dest_port = pick_port();
            end
            if ($urandom_range(15) == 0) begin
                r.dest_port = r.source_port;
            end
        end
        return r;
    endfunction

    task automatic enqueue(input hist_req_t r);
        pending.push_back(r);
        sent_total++;
    endtask

    task automatic wait_drained();
        while (taken_total != sent_total || readings_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // a trailing read fences off any count still in flight
    task automatic settle();
        enqueue(read_item(pick_port()));
        wait_drained();
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [LEN_W-1:0] len);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        interval_len = len;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // random requests; interval restarts are costly so only a few are let through
    task automatic run_random(input int unsigned n, input int unsigned sweeps);
        hist_req_t   r;
        int unsigned useful;
        useful = 0;
        while (useful < n) begin
            r = random_request();
            if (r.req_type == REQ_COUNT && r.is_tcp_or_udp && r.is_new_interval) begin
                if (sweeps == 0 || $urandom_range(39) != 0) begin
                    r.is_new_interval = 1'b0;
                end else begin
                    sweeps--;
                end
            end
            if (r.req_type == REQ_READ || r.is_tcp_or_udp) begin
                useful++;
            end
            enqueue(r);
        end
    endtask

    initial begin : stimulus
        hist_req_t r;
        hot_ports[0] = '0;
        hot_ports[1] = '1;
        for (int i = 2; i < 8; i++) begin
            hot_ports[i] = PORT_W'($urandom);
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, interval length at its reset value of one
        enqueue(read_item('0));
        enqueue(read_item('1));
        enqueue(count_item(1'b0, 1'b1, SECS_W'(5), '0, '1));
        enqueue(count_item(1'b0, 1'b1, SECS_W'(77), PORT_W'(1234), PORT_W'(1234)));
        // not tcp or udp: restart flag has no effect
        enqueue(count_item(1'b1, 1'b0, '1, '0, '0));
        enqueue(read_item('0));
        enqueue(read_item('1));
        enqueue(read_item(PORT_W'(1234)));
        enqueue(count_item(1'b1, 1'b1, '1, '1, PORT_W'(7)));
        r = read_item('0);
        r.is_new_interval = 1'b1;
        r.is_tcp_or_udp   = 1'b1;
        enqueue(r);
        enqueue(read_item('1));
        enqueue(read_item(PORT_W'(7)));
        enqueue(read_item(PORT_W'(1234)));
        settle();

        // longest legal interval
        write_interval(LEN_W'(86400));
        enqueue(count_item(1'b1, 1'b1, SECS_W'(1000000007), PORT_W'(80), PORT_W'(443)));
        enqueue(count_item(1'b0, 1'b1, '0, PORT_W'(443), PORT_W'(80)));
        enqueue(read_item(PORT_W'(443)));
        enqueue(read_item(PORT_W'(80)));
        enqueue(read_item('1));
        settle();

        // zero length behaves as one
        write_interval('0);
        enqueue(count_item(1'b1, 1'b1, SECS_W'(12345), '1, '1));
        enqueue(read_item('1));
        enqueue(read_item('0));
        settle();

        // random, sender idles less than receiver, with a pause to drain midway
        write_interval(LEN_W'($urandom_range(86399, 2)));
        tx_idle_pct = 38;
        rx_idle_pct = 61;
        run_random(255, 1);
        wait_drained();
        run_random(255, 1);
        settle();

        // random, roles swapped, all-ones interval register
        write_interval('1);
        tx_idle_pct = 61;
        rx_idle_pct = 38;
        run_random(510, 1);
        settle();

        // random, no idling, with a long receiver hold-off to back the block up
        write_interval(LEN_W'(1));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(250, 0);
        wait_drained();
        hold_asks++;
        for (int i = 0; i < 40; i++) begin
            enqueue(read_item(pick_port()));
        end
        run_random(240, 1);
        settle();

        repeat (16) @(posedge aclk);
        if (readings_due.size() != 0) begin
            $error("%0d results never arrived", readings_due.size());
            fails++;
        end
        $display("covered %0d counted packets, %0d ignored packets, %0d bin reads checked",
                 packets_counted, packets_ignored, reads_checked);
        $display("with %0d interval restarts over %0d interval length settings",
                 clears, cfg_writes);
        if (fails == 0) begin
            $display("PASS port_usage_histogram");
        end else begin
            $display("FAIL port_usage_histogram");
        end
        $finish;
    end

endmodule
